[rtl/c3p_pkg.sv]
// c3p_pkg: widths, word types, register-file map and microcode for the
// circle-through-three-points core. No dependencies.
package c3p_pkg;

	localparam int CW       = 32;
	localparam int FB       = 16;
	localparam int DW       = CW + 1;
	localparam int NW       = FB + 2;
	localparam int WW       = 6 * DW + 14;
	localparam int QW       = 2 * CW + 3;
	localparam int SQ_STEPS = CW + 1;
	localparam int NSH      = 2 * FB + 2;
	localparam int CNT_W    = $clog2(QW);
	localparam int FQ_DEPTH = 4;
	localparam int FQ_AW    = $clog2(FQ_DEPTH);
	localparam int RF_DEPTH = 32;
	localparam int RA_W     = $clog2(RF_DEPTH);
	localparam int PROG_LEN = 93;
	localparam int PC_W     = $clog2(PROG_LEN);

	typedef logic signed [CW-1:0] coord_t;
	typedef logic signed [DW-1:0] diff_t;
	typedef logic signed [NW-1:0] norm_t;
	typedef logic [CW-2:0]        rad_t;
	typedef logic signed [WW-1:0] wide_t;
	typedef logic [WW-1:0]        uwide_t;
	typedef logic [RA_W-1:0]      ra_t;

	typedef struct packed {
		coord_t ax, ay, az;
		diff_t  ux, uy, uz;
		diff_t  vx, vy, vz;
		diff_t  ex, ey, ez;
		logic   coin;
	} item_t;

	typedef struct packed {
		coord_t cx, cy, cz;
		rad_t   rad;
		norm_t  nx, ny, nz;
		coord_t off;
		logic   degen;
	} res_t;

	typedef enum logic [3:0] {
		OP_LD, OP_ADD, OP_SUB, OP_MUL, OP_DIVF, OP_DIVR, OP_SQRT, OP_NSC,
		OP_BRZ, OP_OUTC, OP_OUTR, OP_OUTN, OP_OUTP, OP_DONE
	} op_t;

	typedef struct packed {
		op_t op;
		ra_t dst;
		ra_t s1;
		ra_t s2;
	} instr_t;

	localparam ra_t R_AX = 5'd0,  R_AY = 5'd1,  R_AZ = 5'd2;
	localparam ra_t R_UX = 5'd3,  R_UY = 5'd4,  R_UZ = 5'd5;
	localparam ra_t R_VX = 5'd6,  R_VY = 5'd7,  R_VZ = 5'd8;
	localparam ra_t R_EX = 5'd9,  R_EY = 5'd10, R_EZ = 5'd11;
	localparam ra_t R_WX = 5'd12, R_WY = 5'd13, R_WZ = 5'd14;
	localparam ra_t R_QX = 5'd15, R_QY = 5'd16, R_QZ = 5'd17;
	localparam ra_t R_NX = 5'd18, R_NY = 5'd19, R_NZ = 5'd20;
	localparam ra_t R_V11 = 5'd21, R_V22 = 5'd22, R_V12 = 5'd23;
	localparam ra_t R_EE = 5'd24, R_DEN = 5'd25, R_AA = 5'd26, R_BB = 5'd27;
	localparam ra_t R_T = 5'd28, R_T2 = 5'd29, R_NIL = 5'd31;
	localparam ra_t AXIS_X = 5'd0, AXIS_Y = 5'd1, AXIS_Z = 5'd2;

	// W = U x V, dot products, den = |W|^2, centre, radius, normal, offset
	localparam instr_t PROG [PROG_LEN] = '{
		'{OP_LD, R_AX, R_NIL, R_NIL}, '{OP_LD, R_AY, R_NIL, R_NIL},
		'{OP_LD, R_AZ, R_NIL, R_NIL}, '{OP_LD, R_UX, R_NIL, R_NIL},
		'{OP_LD, R_UY, R_NIL, R_NIL}, '{OP_LD, R_UZ, R_NIL, R_NIL},
		'{OP_LD, R_VX, R_NIL, R_NIL}, '{OP_LD, R_VY, R_NIL, R_NIL},
		'{OP_LD, R_VZ, R_NIL, R_NIL}, '{OP_LD, R_EX, R_NIL, R_NIL},
		'{OP_LD, R_EY, R_NIL, R_NIL}, '{OP_LD, R_EZ, R_NIL, R_NIL},
		'{OP_MUL, R_T, R_UY, R_VZ}, '{OP_MUL, R_T2, R_UZ, R_VY},
		'{OP_SUB, R_WX, R_T, R_T2},
		'{OP_MUL, R_T, R_UZ, R_VX}, '{OP_MUL, R_T2, R_UX, R_VZ},
		'{OP_SUB, R_WY, R_T, R_T2},
		'{OP_MUL, R_T, R_UX, R_VY}, '{OP_MUL, R_T2, R_UY, R_VX},
		'{OP_SUB, R_WZ, R_T, R_T2},
		'{OP_MUL, R_V11, R_UX, R_UX}, '{OP_MUL, R_T, R_UY, R_UY},
		'{OP_ADD, R_V11, R_V11, R_T}, '{OP_MUL, R_T, R_UZ, R_UZ},
		'{OP_ADD, R_V11, R_V11, R_T},
		'{OP_MUL, R_V22, R_VX, R_VX}, '{OP_MUL, R_T, R_VY, R_VY},
		'{OP_ADD, R_V22, R_V22, R_T}, '{OP_MUL, R_T, R_VZ, R_VZ},
		'{OP_ADD, R_V22, R_V22, R_T},
		'{OP_MUL, R_V12, R_UX, R_VX}, '{OP_MUL, R_T, R_UY, R_VY},
		'{OP_ADD, R_V12, R_V12, R_T}, '{OP_MUL, R_T, R_UZ, R_VZ},
		'{OP_ADD, R_V12, R_V12, R_T},
		'{OP_MUL, R_EE, R_EX, R_EX}, '{OP_MUL, R_T, R_EY, R_EY},
		'{OP_ADD, R_EE, R_EE, R_T}, '{OP_MUL, R_T, R_EZ, R_EZ},
		'{OP_ADD, R_EE, R_EE, R_T},
		'{OP_MUL, R_QX, R_WX, R_WX}, '{OP_MUL, R_QY, R_WY, R_WY},
		'{OP_MUL, R_QZ, R_WZ, R_WZ}, '{OP_ADD, R_DEN, R_QX, R_QY},
		'{OP_ADD, R_DEN, R_DEN, R_QZ},
		'{OP_BRZ, R_NIL, R_DEN, R_NIL},
		'{OP_SUB, R_T, R_V11, R_V12}, '{OP_MUL, R_AA, R_T, R_V22},
		'{OP_SUB, R_T, R_V22, R_V12}, '{OP_MUL, R_BB, R_T, R_V11},
		'{OP_MUL, R_T, R_AA, R_UX}, '{OP_MUL, R_T2, R_BB, R_VX},
		'{OP_ADD, R_T, R_T, R_T2}, '{OP_DIVR, R_T, R_T, R_DEN},
		'{OP_ADD, R_T, R_AX, R_T}, '{OP_OUTC, AXIS_X, R_T, R_NIL},
		'{OP_MUL, R_T, R_AA, R_UY}, '{OP_MUL, R_T2, R_BB, R_VY},
		'{OP_ADD, R_T, R_T, R_T2}, '{OP_DIVR, R_T, R_T, R_DEN},
		'{OP_ADD, R_T, R_AY, R_T}, '{OP_OUTC, AXIS_Y, R_T, R_NIL},
		'{OP_MUL, R_T, R_AA, R_UZ}, '{OP_MUL, R_T2, R_BB, R_VZ},
		'{OP_ADD, R_T, R_T, R_T2}, '{OP_DIVR, R_T, R_T, R_DEN},
		'{OP_ADD, R_T, R_AZ, R_T}, '{OP_OUTC, AXIS_Z, R_T, R_NIL},
		'{OP_MUL, R_T, R_V11, R_V22}, '{OP_MUL, R_T, R_T, R_EE},
		'{OP_DIVF, R_T, R_T, R_DEN}, '{OP_SQRT, R_T, R_T, R_NIL},
		'{OP_OUTR, R_NIL, R_T, R_NIL},
		'{OP_NSC, R_T, R_QX, R_NIL}, '{OP_DIVF, R_T, R_T, R_DEN},
		'{OP_SQRT, R_T, R_T, R_NIL}, '{OP_OUTN, R_NX, R_T, R_WX},
		'{OP_NSC, R_T, R_QY, R_NIL}, '{OP_DIVF, R_T, R_T, R_DEN},
		'{OP_SQRT, R_T, R_T, R_NIL}, '{OP_OUTN, R_NY, R_T, R_WY},
		'{OP_NSC, R_T, R_QZ, R_NIL}, '{OP_DIVF, R_T, R_T, R_DEN},
		'{OP_SQRT, R_T, R_T, R_NIL}, '{OP_OUTN, R_NZ, R_T, R_WZ},
		'{OP_MUL, R_T, R_AX, R_NX}, '{OP_MUL, R_T2, R_AY, R_NY},
		'{OP_ADD, R_T, R_T, R_T2}, '{OP_MUL, R_T2, R_AZ, R_NZ},
		'{OP_ADD, R_T, R_T, R_T2}, '{OP_OUTP, R_NIL, R_T, R_NIL},
		'{OP_DONE, R_NIL, R_NIL, R_NIL}
	};

	function automatic coord_t sat_coord(wide_t v);
		wide_t hi;
		wide_t lo;
		hi = (wide_t'(1) <<< (CW - 1)) - wide_t'(1);
		lo = -(wide_t'(1) <<< (CW - 1));
		if (v > hi)
			return coord_t'(hi);
		else if (v < lo)
			return coord_t'(lo);
		else
			return coord_t'(v);
	endfunction

endpackage

[rtl/c3p_ram.sv]
// c3p_ram: generic RAM, one write port, two registered read ports.
// No dependencies.
module c3p_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wa,
	input  logic [WIDTH-1:0]         wd,
	input  logic [$clog2(DEPTH)-1:0] ra0,
	output logic [WIDTH-1:0]         rd0,
	input  logic [$clog2(DEPTH)-1:0] ra1,
	output logic [WIDTH-1:0]         rd1
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[wa] <= wd;
		rd0 <= mem[ra0];
		rd1 <= mem[ra1];
	end
endmodule

[rtl/c3p_front.sv]
// c3p_front: accepts point triples, forms the edge vectors, flags coincident
// points and holds words in a short queue for the back end. Uses c3p_pkg.
module c3p_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  c3p_pkg::coord_t point_a_x,
	input  c3p_pkg::coord_t point_a_y,
	input  c3p_pkg::coord_t point_a_z,
	input  c3p_pkg::coord_t point_b_x,
	input  c3p_pkg::coord_t point_b_y,
	input  c3p_pkg::coord_t point_b_z,
	input  c3p_pkg::coord_t point_c_x,
	input  c3p_pkg::coord_t point_c_y,
	input  c3p_pkg::coord_t point_c_z,
	output logic            item_valid,
	output c3p_pkg::item_t  item,
	input  logic            item_take
);
	import c3p_pkg::*;

	item_t            fq_q [FQ_DEPTH];
	logic [FQ_AW-1:0] wp_q, rp_q;
	logic [FQ_AW:0]   cnt_q;
	item_t            nw;
	logic             wr, rd;

	always_comb begin
		nw.ax = point_a_x;
		nw.ay = point_a_y;
		nw.az = point_a_z;
		nw.ux = diff_t'(point_b_x) - diff_t'(point_a_x);
		nw.uy = diff_t'(point_b_y) - diff_t'(point_a_y);
		nw.uz = diff_t'(point_b_z) - diff_t'(point_a_z);
		nw.vx = diff_t'(point_c_x) - diff_t'(point_a_x);
		nw.vy = diff_t'(point_c_y) - diff_t'(point_a_y);
		nw.vz = diff_t'(point_c_z) - diff_t'(point_a_z);
		nw.ex = diff_t'(point_b_x) - diff_t'(point_c_x);
		nw.ey = diff_t'(point_b_y) - diff_t'(point_c_y);
		nw.ez = diff_t'(point_b_z) - diff_t'(point_c_z);
		// a = b or a = c: no plane, skip the arithmetic
		nw.coin = ((nw.ux == '0) && (nw.uy == '0) && (nw.uz == '0)) ||
			((nw.vx == '0) && (nw.vy == '0) && (nw.vz == '0));
	end

	assign full       = (cnt_q == (FQ_AW + 1)'(FQ_DEPTH));
	assign item_valid = (cnt_q != '0);
	assign item       = fq_q[rp_q];
	assign wr         = push && !full;
	assign rd         = item_take && item_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr)
				wp_q <= wp_q + 1'b1;
			if (rd)
				rp_q <= rp_q + 1'b1;
			if (wr && !rd)
				cnt_q <= cnt_q + 1'b1;
			else if (rd && !wr)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr)
			fq_q[wp_q] <= nw;
	end
endmodule

[rtl/c3p_back.sv]
// c3p_back: microcoded back end; serial multiplier, restoring divider and
// root unit around a register file (c3p_ram). Uses c3p_pkg.
module c3p_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	input  c3p_pkg::item_t item,
	output logic           item_take,
	input  logic           res_full,
	output logic           res_push,
	output c3p_pkg::res_t  res
);
	import c3p_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_ISSUE = 7'b0000010,
		ST_EXEC  = 7'b0000100,
		ST_MUL   = 7'b0001000,
		ST_DIV   = 7'b0010000,
		ST_SQRT  = 7'b0100000,
		ST_OUT   = 7'b1000000
	} state_t;

	localparam uwide_t SQ_MAX  = uwide_t'(1) << (2 * CW);
	localparam logic [QW-1:0] QLIM = QW'(1) << CW;
	localparam wide_t  OFF_LIM = wide_t'(1) <<< CW;
	localparam wide_t  RAD_MAX = (wide_t'(1) <<< (CW - 1)) - wide_t'(1);

	state_t           state_q;
	logic [PC_W-1:0]  pc_q;
	logic [CNT_W-1:0] cnt_q;
	item_t            item_q;
	res_t             res_q;
	uwide_t           x_q, y_q, acc_q, rem_q, dsr_q;
	logic [QW-1:0]    q_q;
	logic             neg_q, divr_q;

	instr_t ins;
	wide_t  rd1, rd2, wd, ld_val;
	logic   we;
	uwide_t abs1, abs2;

	logic          div_ge;
	logic [QW-1:0] q_n, dmag;
	wide_t         div_res, mul_res;
	uwide_t        sq_t, sq_res_n;
	logic          sq_ge;
	wide_t         nm, nrm_w, rs, pm, off_w;
	uwide_t        pa;

	assign ins = PROG[pc_q];

	c3p_ram #(.WIDTH(WW), .DEPTH(RF_DEPTH)) u_rf (
		.clk (clk),
		.we  (we),
		.wa  (ins.dst),
		.wd  (wd),
		.ra0 (ins.s1),
		.rd0 (rd1),
		.ra1 (ins.s2),
		.rd1 (rd2)
	);

	assign abs1 = uwide_t'(rd1[WW-1] ? -rd1 : rd1);
	assign abs2 = uwide_t'(rd2[WW-1] ? -rd2 : rd2);

	always_comb begin
		unique case (ins.dst)
			R_AX:    ld_val = wide_t'(item_q.ax);
			R_AY:    ld_val = wide_t'(item_q.ay);
			R_AZ:    ld_val = wide_t'(item_q.az);
			R_UX:    ld_val = wide_t'(item_q.ux);
			R_UY:    ld_val = wide_t'(item_q.uy);
			R_UZ:    ld_val = wide_t'(item_q.uz);
			R_VX:    ld_val = wide_t'(item_q.vx);
			R_VY:    ld_val = wide_t'(item_q.vy);
			R_VZ:    ld_val = wide_t'(item_q.vz);
			R_EX:    ld_val = wide_t'(item_q.ex);
			R_EY:    ld_val = wide_t'(item_q.ey);
			R_EZ:    ld_val = wide_t'(item_q.ez);
			default: ld_val = '0;
		endcase
	end

	// divider and root steps
	always_comb begin
		div_ge  = (rem_q >= dsr_q);
		q_n     = {q_q[QW-2:0], div_ge};
		dmag    = (q_n > QLIM) ? QLIM : q_n;
		if (divr_q)
			div_res = neg_q ? -wide_t'(dmag) : wide_t'(dmag);
		else
			div_res = q_n[QW-1] ? wide_t'({(QW-1){1'b1}}) : wide_t'(q_n[QW-2:0]);
		mul_res  = neg_q ? -wide_t'(acc_q) : wide_t'(acc_q);
		sq_t     = acc_q + x_q;
		sq_ge    = (rem_q >= sq_t);
		sq_res_n = sq_ge ? (acc_q >> 1) + x_q : acc_q >> 1;
	end

	// output formatting
	always_comb begin
		nm    = (rd1 + wide_t'(1)) >>> 1;
		nrm_w = rd2[WW-1] ? -nm : nm;
		rs    = (rd1 + wide_t'(1)) >>> 1;
		if (rs > RAD_MAX)
			rs = RAD_MAX;
		pa    = abs1 + (uwide_t'(1) << (FB - 1));
		pm    = wide_t'(pa >> FB);
		if (pm > OFF_LIM)
			pm = OFF_LIM;
		off_w = rd1[WW-1] ? pm : -pm;
	end

	always_comb begin
		we = 1'b0;
		wd = '0;
		unique case (state_q)
			ST_EXEC: begin
				unique case (ins.op)
					OP_LD: begin
						we = 1'b1;
						wd = ld_val;
					end
					OP_ADD: begin
						we = 1'b1;
						wd = rd1 + rd2;
					end
					OP_SUB: begin
						we = 1'b1;
						wd = rd1 - rd2;
					end
					OP_NSC: begin
						we = 1'b1;
						wd = rd1 <<< NSH;
					end
					OP_OUTN: begin
						we = 1'b1;
						wd = nrm_w;
					end
					default: ;
				endcase
			end
			ST_MUL: begin
				we = (y_q == '0);
				wd = mul_res;
			end
			ST_DIV: begin
				we = (cnt_q == '0);
				wd = div_res;
			end
			ST_SQRT: begin
				we = (cnt_q == '0);
				wd = wide_t'(sq_res_n);
			end
			default: ;
		endcase
	end

	assign item_take = (state_q == ST_IDLE) && item_valid;
	assign res_push  = (state_q == ST_OUT) && !res_full;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q    <= '0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						pc_q    <= '0;
						state_q <= item.coin ? ST_OUT : ST_ISSUE;
					end
				end
				ST_ISSUE: state_q <= ST_EXEC;
				ST_EXEC: begin
					unique case (ins.op)
						OP_MUL: state_q <= ST_MUL;
						OP_DIVF, OP_DIVR: begin
							cnt_q   <= CNT_W'(QW - 1);
							state_q <= ST_DIV;
						end
						OP_SQRT: begin
							cnt_q   <= CNT_W'(SQ_STEPS - 1);
							state_q <= ST_SQRT;
						end
						OP_BRZ: begin
							if (rd1 == '0)
								state_q <= ST_OUT;
							else begin
								pc_q    <= pc_q + 1'b1;
								state_q <= ST_ISSUE;
							end
						end
						OP_DONE: state_q <= ST_OUT;
						default: begin
							pc_q    <= pc_q + 1'b1;
							state_q <= ST_ISSUE;
						end
					endcase
				end
				ST_MUL: begin
					if (y_q == '0) begin
						pc_q    <= pc_q + 1'b1;
						state_q <= ST_ISSUE;
					end
				end
				ST_DIV, ST_SQRT: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						pc_q    <= pc_q + 1'b1;
						state_q <= ST_ISSUE;
					end
				end
				ST_OUT: begin
					if (!res_full)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					item_q <= item;
					res_q  <= '{degen: item.coin, default: '0};
				end
			end
			ST_EXEC: begin
				unique case (ins.op)
					OP_MUL: begin
						x_q   <= abs1;
						y_q   <= abs2;
						acc_q <= '0;
						neg_q <= rd1[WW-1] ^ rd2[WW-1];
					end
					OP_DIVF: begin
						rem_q  <= uwide_t'(rd1);
						dsr_q  <= uwide_t'(rd2) << (QW - 1);
						q_q    <= '0;
						divr_q <= 1'b0;
					end
					OP_DIVR: begin
						rem_q  <= abs1 + uwide_t'(rd2);
						dsr_q  <= uwide_t'(rd2) << QW;
						q_q    <= '0;
						divr_q <= 1'b1;
						neg_q  <= rd1[WW-1];
					end
					OP_SQRT: begin
						rem_q <= (uwide_t'(rd1) > SQ_MAX) ? SQ_MAX : uwide_t'(rd1);
						acc_q <= '0;
						x_q   <= SQ_MAX;
					end
					OP_BRZ: begin
						if (rd1 == '0)
							res_q <= '{degen: 1'b1, default: '0};
					end
					OP_OUTC: begin
						unique case (ins.dst)
							AXIS_X:  res_q.cx <= sat_coord(rd1);
							AXIS_Y:  res_q.cy <= sat_coord(rd1);
							default: res_q.cz <= sat_coord(rd1);
						endcase
					end
					OP_OUTR: res_q.rad <= rad_t'(rs);
					OP_OUTN: begin
						unique case (ins.dst)
							R_NX:    res_q.nx <= norm_t'(nrm_w);
							R_NY:    res_q.ny <= norm_t'(nrm_w);
							default: res_q.nz <= norm_t'(nrm_w);
						endcase
					end
					OP_OUTP: res_q.off <= sat_coord(off_w);
					default: ;
				endcase
			end
			ST_MUL: begin
				if (y_q != '0) begin
					if (y_q[0])
						acc_q <= acc_q + x_q;
					x_q <= x_q << 1;
					y_q <= y_q >> 1;
				end
			end
			ST_DIV: begin
				if (div_ge)
					rem_q <= rem_q - dsr_q;
				dsr_q <= dsr_q >> 1;
				q_q   <= q_n;
			end
			ST_SQRT: begin
				if (sq_ge)
					rem_q <= rem_q - sq_t;
				acc_q <= sq_res_n;
				x_q   <= x_q >> 2;
			end
			default: ;
		endcase
	end
endmodule

[rtl/c3p_outq.sv]
// c3p_outq: two-word result queue between the back end and the result port.
// Uses c3p_pkg.
module c3p_outq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          res_push,
	input  c3p_pkg::res_t res_in,
	output logic          res_full,
	input  logic          pop,
	output logic          empty,
	output c3p_pkg::res_t res_out
);
	import c3p_pkg::*;

	res_t       oq_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       wr, rd;

	assign res_full = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign res_out  = oq_q[rp_q];
	assign wr       = res_push && !res_full;
	assign rd       = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr)
				wp_q <= !wp_q;
			if (rd)
				rp_q <= !rp_q;
			if (wr && !rd)
				cnt_q <= cnt_q + 1'b1;
			else if (rd && !wr)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr)
			oq_q[wp_q] <= res_in;
	end
endmodule

[rtl/circle_through_three_points_3d_core.sv]
// circle_through_three_points_3d_core: top level; front queue, microcoded
// back end and result queue. Uses c3p_pkg, c3p_front, c3p_back, c3p_outq.
//
// Takes three points (Q16 fixed point) and returns the circumcircle centre,
// radius, unit plane normal and plane offset, or the degenerate flag with all
// else zero. The front queue holds four triples, so push is taken while
// earlier triples are still being worked on. The back end runs a 93-step
// microprogram one step at a time over a 32-word register file: each step
// passes through an issue and an execute state; a product adds multiply
// steps that end once its second operand is shifted out, a division or
// square root adds divide or root steps, and coincident points go straight
// to the output state.
module circle_through_three_points_3d_core
	import c3p_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	output logic   full,
	input  coord_t point_a_x,
	input  coord_t point_a_y,
	input  coord_t point_a_z,
	input  coord_t point_b_x,
	input  coord_t point_b_y,
	input  coord_t point_b_z,
	input  coord_t point_c_x,
	input  coord_t point_c_y,
	input  coord_t point_c_z,
	output logic   empty,
	input  logic   pop,
	output coord_t center_x,
	output coord_t center_y,
	output coord_t center_z,
	output rad_t   circle_radius,
	output norm_t  normal_x,
	output norm_t  normal_y,
	output norm_t  normal_z,
	output coord_t plane_offset,
	output logic   degenerate
);
	item_t item;
	logic  item_valid, item_take;
	res_t  res_b, res_o;
	logic  res_push, res_full;

	c3p_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.point_a_x  (point_a_x),
		.point_a_y  (point_a_y),
		.point_a_z  (point_a_z),
		.point_b_x  (point_b_x),
		.point_b_y  (point_b_y),
		.point_b_z  (point_b_z),
		.point_c_x  (point_c_x),
		.point_c_y  (point_c_y),
		.point_c_z  (point_c_z),
		.item_valid (item_valid),
		.item       (item),
		.item_take  (item_take)
	);

	c3p_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.item_take  (item_take),
		.res_full   (res_full),
		.res_push   (res_push),
		.res        (res_b)
	);

	c3p_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res_in   (res_b),
		.res_full (res_full),
		.pop      (pop),
		.empty    (empty),
		.res_out  (res_o)
	);

	assign center_x      = res_o.cx;
	assign center_y      = res_o.cy;
	assign center_z      = res_o.cz;
	assign circle_radius = res_o.rad;
	assign normal_x      = res_o.nx;
	assign normal_y      = res_o.ny;
	assign normal_z      = res_o.nz;
	assign plane_offset  = res_o.off;
	assign degenerate    = res_o.degen;
endmodule

[rtl/c3p_checker.sv]
// c3p_checker: port-level checks on the result side, bound to the top level.
// Uses c3p_pkg.
module c3p_checker
	import c3p_pkg::*;
(
	input logic   clk,
	input logic   arst_n,
	input logic   empty,
	input logic   pop,
	input coord_t center_x,
	input coord_t center_y,
	input coord_t center_z,
	input rad_t   circle_radius,
	input norm_t  normal_x,
	input norm_t  normal_y,
	input norm_t  normal_z,
	input coord_t plane_offset,
	input logic   degenerate
);
	localparam norm_t NMAX = norm_t'(1) <<< FB;

	a_reset_empty: assert property (@(posedge clk) $rose(arst_n) |-> empty)
		else $error("result queue not empty after reset");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && degenerate) |-> (center_x == '0 && center_y == '0 &&
		center_z == '0 && circle_radius == '0 && normal_x == '0 &&
		normal_y == '0 && normal_z == '0 && plane_offset == '0))
		else $error("degenerate word carries non-zero fields");

	a_normal_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (normal_x <= NMAX && normal_x >= -NMAX &&
		normal_y <= NMAX && normal_y >= -NMAX &&
		normal_z <= NMAX && normal_z >= -NMAX))
		else $error("normal component out of range");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(center_x) &&
		$stable(plane_offset) && $stable(degenerate)))
		else $error("waiting result word changed");
endmodule

bind circle_through_three_points_3d_core c3p_checker u_chk (.*);
